// ===== design/iobad_pkg.sv =====
// Shared types and constants for the I/O bus address decoder.
package iobad_pkg;

  // Input beat: one bus access.
  typedef struct packed {
    logic        op;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_beat_t;

  // Result beat: decoded target.
  typedef struct packed {
    logic [3:0]  route;
    logic [28:0] target_offset;
    logic [31:0] read_data;
    logic        invalidate;
    logic [31:0] invalidate_address;
  } out_beat_t;

  // Operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_RSVD = 2'd3;

  // Route codes
  localparam logic [3:0] RT_RAM      = 4'd0;
  localparam logic [3:0] RT_EXP      = 4'd1;
  localparam logic [3:0] RT_SCRATCH  = 4'd2;
  localparam logic [3:0] RT_HWREGS   = 4'd3;
  localparam logic [3:0] RT_HW4      = 4'd4;
  localparam logic [3:0] RT_ROM      = 4'd5;
  localparam logic [3:0] RT_ROM1     = 4'd6;
  localparam logic [3:0] RT_MBSTORE  = 4'd7;
  localparam logic [3:0] RT_SOUND    = 4'd8;
  localparam logic [3:0] RT_BAY      = 4'd9;
  localparam logic [3:0] RT_INTERNAL = 4'd10;
  localparam logic [3:0] RT_UNMAPPED = 4'd11;

  // Mailbox register indexes with special rules
  localparam logic [3:0] MB_BASE_IDX = 4'd0;
  localparam logic [3:0] MB_SET_IDX  = 4'd1;
  localparam logic [3:0] MB_CLR_IDX  = 4'd2;
  localparam logic [3:0] MB_OR_IDX   = 4'd3;
  localparam logic [3:0] MB_TGL_IDX  = 4'd4;
  localparam logic [3:0] MB_ZERO_IDX = 4'd6;

  // Region pages (masked to 13 bits where noted)
  localparam logic [12:0] T_SCRATCH = 13'h1f80;
  localparam logic [12:0] T_HW4     = 13'h1f40;
  localparam logic [12:0] T_MAILBOX = 13'h1d00;
  localparam logic [12:0] T_BAY     = 13'h1000;
  localparam logic [12:0] T_SOUND   = 13'h1f90;
  localparam logic [15:0] P_EXP     = 16'h1f00;
  localparam logic [15:0] P_MB_A    = 16'h1d00;
  localparam logic [15:0] P_MB_B    = 16'hbd00;
  localparam logic [15:0] P_ROM_A   = 16'h1fc0;
  localparam logic [15:0] P_ROM_B   = 16'h9fc0;
  localparam logic [15:0] P_ROM_C   = 16'hbfc0;
  localparam logic [15:0] P_ROM1_A  = 16'h1e00;
  localparam logic [15:0] P_ROM1_B  = 16'h9e00;
  localparam logic [15:0] P_ROM1_C  = 16'hbe00;
  localparam logic [15:0] ROM_MASK  = 16'hffc0;
  localparam logic [15:0] ROM1_MASK = 16'hfffc;
  localparam logic [8:0]  RAM_SEG_A = 9'h000;
  localparam logic [8:0]  RAM_SEG_B = 9'h100;
  localparam logic [8:0]  RAM_SEG_C = 9'h140;
  localparam logic [28:0] HWREGS_BASE = 29'h1f801000;

  // Write-control register
  localparam logic [31:0] CTRL_ADDR = 32'hfffe0130;
  localparam logic [31:0] CTL_OFF_A = 32'h00000800;
  localparam logic [31:0] CTL_OFF_B = 32'h00000804;
  localparam logic [31:0] CTL_OFF_C = 32'h00000c00;
  localparam logic [31:0] CTL_OFF_D = 32'h00000c04;
  localparam logic [31:0] CTL_OFF_E = 32'h00000cc0;
  localparam logic [31:0] CTL_OFF_F = 32'h00000cc4;
  localparam logic [31:0] CTL_OFF_G = 32'h000000c4;
  localparam logic [31:0] CTL_ON_A  = 32'h0001e988;
  localparam logic [31:0] CTL_ON_B  = 32'h0001edd8;

  // Mailbox read/toggle constants
  localparam logic [31:0] MB_HALF_OR = 32'h00000002;
  localparam logic [31:0] MB_WORD_OR = 32'hf0000002;
  localparam logic [31:0] TGL_HI_SEL = 32'h000000a0;
  localparam logic [31:0] TGL_BITS   = 32'h000000f0;
  localparam logic [3:0]  TGL_NIBBLE = 4'h2;

endpackage

// ===== design/io_bus_address_decoder.sv =====
// I/O bus address decoder: region decode, mailbox registers and write control.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) carries one bus access per beat:
//   op, access_size, address and write_data. The result channel
//   (out_valid/out_ready/out_data) returns exactly one beat per access with the
//   target route, offset, internal read data and the code-invalidate request.
//   Accesses are handled strictly in order; mailbox, write-control and RAM
//   write-enable updates from one access are seen by the next.
// Timing
//   Two register stages: an input register and a result register. A beat
//   accepted moves from the input register to the result register and out_*.
//   Throughput is one beat per cycle while out_ready is high; the decode between
//   the two registers is a few compares, one small constant page table and a 16:1 mailbox mux.
// Reset
//   rst_n is synchronous, active low. Both stages empty, RAM writes enabled,
//   write control zero, mailbox words zero.
// Stalls
//   With out_ready low the result beat holds and the input register keeps one
//   more beat; in_ready drops only when both are full. State is updated as a
//   beat moves into the result register, so stalls never repeat an update.
module io_bus_address_decoder #(
  parameter int RAM_PAGES     = 32,  // 1..128
  parameter int MAILBOX_WORDS = 16   // 8..16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iobad_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iobad_pkg::out_beat_t out_data
);

  localparam int MB_IW = (MAILBOX_WORDS > 1) ? $clog2(MAILBOX_WORDS) : 1;
  localparam logic [4:0] MB_CNT = 5'(MAILBOX_WORDS);
  localparam logic [MB_IW-1:0] I_SET  = MB_IW'(iobad_pkg::MB_SET_IDX);
  localparam logic [MB_IW-1:0] I_CLR  = MB_IW'(iobad_pkg::MB_CLR_IDX);
  localparam logic [MB_IW-1:0] I_OR   = MB_IW'(iobad_pkg::MB_OR_IDX);
  localparam logic [MB_IW-1:0] I_TGL  = MB_IW'(iobad_pkg::MB_TGL_IDX);
  localparam logic [MB_IW-1:0] I_ZERO = MB_IW'(iobad_pkg::MB_ZERO_IDX);

  // Pipeline registers
  logic                 s1_valid_r;
  iobad_pkg::in_beat_t  s1_r;
  logic                 out_valid_r;
  iobad_pkg::out_beat_t out_r;
  logic                 s1_adv;

  // Architectural state
  logic        rwe_r, rwe_nxt;
  logic [31:0] wctl_r, wctl_nxt;
  logic [31:0] mb_r   [MAILBOX_WORDS];
  logic [31:0] mb_nxt [MAILBOX_WORDS];

  // Decode fields of the staged access
  logic [1:0]  sz;
  logic [31:0] a;
  logic [31:0] v;
  logic [15:0] page;
  logic [12:0] t;
  logic [15:0] lo;
  logic [3:0]  sel;
  logic [MB_IW-1:0] sel_i;
  logic        sel_ok;
  logic [31:0] mb_sel_rd;
  logic        is_ram, is_exp, is_rom, is_rom1, is_mbs, rd_hit, wr_hit;
  logic [3:0]  rd_route;
  logic [28:0] rd_off, ram_off;
  logic [31:0] tog, tsel;
  logic [6:0]  ram_mod [128];
  iobad_pkg::out_beat_t res_nxt;

  // Page -> RAM bank table, fixed at elaboration
  for (genvar i = 0; i < 128; i++) begin : g_ram_mod
    assign ram_mod[i] = 7'(i % RAM_PAGES);
  end

  // Handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Operand shaping: size code 3 behaves as a word; narrow stores masked
  assign sz   = (s1_r.access_size == iobad_pkg::SZ_RSVD) ? iobad_pkg::SZ_WORD
                                                          : s1_r.access_size;
  assign a    = s1_r.address;
  assign v    = (sz == iobad_pkg::SZ_BYTE) ? {24'b0, s1_r.write_data[7:0]}  :
                (sz == iobad_pkg::SZ_HALF) ? {16'b0, s1_r.write_data[15:0]} :
                                             s1_r.write_data;
  assign page = a[31:16];
  assign t    = a[28:16];
  assign lo   = a[15:0];
  assign sel  = a[7:4];
  assign sel_i  = sel[MB_IW-1:0];
  assign sel_ok = {1'b0, sel} < MB_CNT;
  assign mb_sel_rd = sel_ok ? mb_r[sel_i] : 32'b0;

  // Region matches
  assign is_ram  = (a[31:23] == iobad_pkg::RAM_SEG_A) || (a[31:23] == iobad_pkg::RAM_SEG_B) ||
                   (a[31:23] == iobad_pkg::RAM_SEG_C);
  assign is_exp  = page == iobad_pkg::P_EXP;
  assign is_rom  = ((page & iobad_pkg::ROM_MASK) == iobad_pkg::P_ROM_A) ||
                   ((page & iobad_pkg::ROM_MASK) == iobad_pkg::P_ROM_B) ||
                   ((page & iobad_pkg::ROM_MASK) == iobad_pkg::P_ROM_C);
  assign is_rom1 = ((page & iobad_pkg::ROM1_MASK) == iobad_pkg::P_ROM1_A) ||
                   ((page & iobad_pkg::ROM1_MASK) == iobad_pkg::P_ROM1_B) ||
                   ((page & iobad_pkg::ROM1_MASK) == iobad_pkg::P_ROM1_C);
  assign is_mbs  = (page == iobad_pkg::P_MB_A) || (page == iobad_pkg::P_MB_B);
  assign ram_off = {6'b0, ram_mod[page[6:0]], lo};
  assign rd_hit  = is_ram || is_exp || is_rom || is_rom1 || is_mbs;
  assign wr_hit  = (rwe_r && is_ram) || is_exp;

  // Read map route/offset, in priority order
  always_comb begin
    priority if (is_ram) begin
      rd_route = iobad_pkg::RT_RAM;
      rd_off   = ram_off;
    end else if (is_exp) begin
      rd_route = iobad_pkg::RT_EXP;
      rd_off   = {13'b0, lo};
    end else if (is_rom) begin
      rd_route = iobad_pkg::RT_ROM;
      rd_off   = {7'b0, page[5:0], lo};
    end else if (is_rom1) begin
      rd_route = iobad_pkg::RT_ROM1;
      rd_off   = {11'b0, page[1:0], lo};
    end else begin
      rd_route = iobad_pkg::RT_MBSTORE;
      rd_off   = {13'b0, lo};
    end
  end

  // Toggle rule for mailbox word 4
  always_comb begin
    tsel = v & iobad_pkg::TGL_BITS;
    tog  = mb_r[I_TGL];
    if (|(v & iobad_pkg::TGL_HI_SEL)) begin
      tog = {tog[31:16], iobad_pkg::TGL_NIBBLE, tog[11:0]};
    end
    if (|(tog & tsel)) begin
      tog = tog & ~tsel;
    end else begin
      tog = tog | tsel;
    end
  end

  // Main decode and state update
  always_comb begin
    res_nxt.route              = iobad_pkg::RT_UNMAPPED;
    res_nxt.target_offset      = a[28:0];
    res_nxt.read_data          = 32'b0;
    res_nxt.invalidate         = 1'b0;
    res_nxt.invalidate_address = 32'b0;
    mb_nxt   = mb_r;
    rwe_nxt  = rwe_r;
    wctl_nxt = wctl_r;

    priority if (t == iobad_pkg::T_SCRATCH) begin
      if (a[28:0] < iobad_pkg::HWREGS_BASE) begin
        res_nxt.route         = iobad_pkg::RT_SCRATCH;
        res_nxt.target_offset = {13'b0, lo};
      end else begin
        res_nxt.route = iobad_pkg::RT_HWREGS;
      end
    end else if (sz == iobad_pkg::SZ_BYTE && t == iobad_pkg::T_HW4) begin
      res_nxt.route = iobad_pkg::RT_HW4;
    end else if (s1_r.op == iobad_pkg::OP_READ) begin
      priority if (rd_hit) begin
        if (sz != iobad_pkg::SZ_BYTE && t == iobad_pkg::T_MAILBOX) begin
          res_nxt.route = iobad_pkg::RT_INTERNAL;
          priority if (sel == iobad_pkg::MB_BASE_IDX || sel == iobad_pkg::MB_SET_IDX ||
                       (sz == iobad_pkg::SZ_WORD &&
                        (sel == iobad_pkg::MB_CLR_IDX || sel == iobad_pkg::MB_OR_IDX))) begin
            res_nxt.read_data = mb_sel_rd;
          end else if (sel == iobad_pkg::MB_TGL_IDX) begin
            res_nxt.read_data = mb_r[I_TGL] | ((sz == iobad_pkg::SZ_HALF) ?
                                iobad_pkg::MB_HALF_OR : iobad_pkg::MB_WORD_OR);
          end else if (sel == iobad_pkg::MB_ZERO_IDX) begin
            res_nxt.read_data = 32'b0;
          end else begin
            res_nxt.route         = iobad_pkg::RT_SCRATCH;
            res_nxt.target_offset = {13'b0, lo};
          end
          if (sz == iobad_pkg::SZ_HALF) begin
            res_nxt.read_data = {16'b0, res_nxt.read_data[15:0]};
          end
        end else begin
          res_nxt.route         = rd_route;
          res_nxt.target_offset = rd_off;
        end
      end else if (t == iobad_pkg::T_BAY) begin
        res_nxt.route = iobad_pkg::RT_BAY;
      end else if (sz == iobad_pkg::SZ_HALF && t == iobad_pkg::T_SOUND) begin
        res_nxt.route = iobad_pkg::RT_SOUND;
      end else if (sz == iobad_pkg::SZ_WORD && a == iobad_pkg::CTRL_ADDR) begin
        res_nxt.route     = iobad_pkg::RT_INTERNAL;
        res_nxt.read_data = wctl_r;
      end else begin
        res_nxt.route = iobad_pkg::RT_UNMAPPED;
      end
    end else begin
      priority if (wr_hit) begin
        res_nxt.route              = is_exp ? iobad_pkg::RT_EXP : iobad_pkg::RT_RAM;
        res_nxt.target_offset      = is_exp ? {13'b0, lo} : ram_off;
        res_nxt.invalidate         = 1'b1;
        res_nxt.invalidate_address = {a[31:2], 2'b00};
      end else if (sz == iobad_pkg::SZ_WORD && a == iobad_pkg::CTRL_ADDR) begin
        res_nxt.route = iobad_pkg::RT_INTERNAL;
        wctl_nxt      = v;
        unique case (v)
          iobad_pkg::CTL_OFF_A, iobad_pkg::CTL_OFF_B, iobad_pkg::CTL_OFF_C,
          iobad_pkg::CTL_OFF_D, iobad_pkg::CTL_OFF_E, iobad_pkg::CTL_OFF_F,
          iobad_pkg::CTL_OFF_G: begin
            rwe_nxt = 1'b0;
          end
          iobad_pkg::CTL_ON_A, iobad_pkg::CTL_ON_B: begin
            rwe_nxt = 1'b1;
          end
          default: begin
            rwe_nxt = rwe_r;
          end
        endcase
      end else if (t == iobad_pkg::T_MAILBOX) begin
        res_nxt.route = iobad_pkg::RT_INTERNAL;
        priority if (sz == iobad_pkg::SZ_HALF && sel == iobad_pkg::MB_SET_IDX) begin
          mb_nxt[I_SET] = {mb_r[I_SET][31:16], v[15:0]};
        end else if (sz == iobad_pkg::SZ_WORD && sel == iobad_pkg::MB_SET_IDX) begin
          mb_nxt[I_SET] = v;
        end else if (sz == iobad_pkg::SZ_WORD && sel == iobad_pkg::MB_CLR_IDX) begin
          mb_nxt[I_CLR] = mb_r[I_CLR] & ~v;
        end else if (sz == iobad_pkg::SZ_WORD && sel == iobad_pkg::MB_OR_IDX) begin
          mb_nxt[I_OR] = mb_r[I_OR] | v;
        end else if (sz != iobad_pkg::SZ_BYTE && sel == iobad_pkg::MB_TGL_IDX) begin
          mb_nxt[I_TGL] = tog;
        end else if (sz != iobad_pkg::SZ_BYTE && sel == iobad_pkg::MB_ZERO_IDX) begin
          mb_nxt[I_ZERO] = 32'b0;
        end else begin
          res_nxt.route         = iobad_pkg::RT_MBSTORE;
          res_nxt.target_offset = {13'b0, lo};
          if (sz == iobad_pkg::SZ_WORD && sel_ok) begin
            mb_nxt[sel_i] = v;
          end
        end
      end else if (t == iobad_pkg::T_BAY) begin
        res_nxt.route = iobad_pkg::RT_BAY;
      end else if (sz == iobad_pkg::SZ_HALF && t == iobad_pkg::T_SOUND) begin
        res_nxt.route = iobad_pkg::RT_SOUND;
      end else begin
        res_nxt.route = iobad_pkg::RT_UNMAPPED;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  // State commits as the beat moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rwe_r  <= 1'b1;
      wctl_r <= 32'b0;
      for (int i = 0; i < MAILBOX_WORDS; i++) begin
        mb_r[i] <= 32'b0;
      end
    end else if (s1_adv) begin
      rwe_r  <= rwe_nxt;
      wctl_r <= wctl_nxt;
      for (int i = 0; i < MAILBOX_WORDS; i++) begin
        mb_r[i] <= mb_nxt[i];
      end
    end
  end

endmodule

// ===== sim/iobad_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the I/O bus address decoder: predicts every access and checks each result.
module iobad_checker #(
  parameter int RAM_PAGES     = 32,
  parameter int MAILBOX_WORDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  iobad_pkg::in_beat_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  iobad_pkg::out_beat_t out_data,
  output int                   fail_count,
  output int                   pending
);

  // Shadow of the decoder state
  logic        ram_wr_en;
  logic [31:0] wr_ctrl;
  logic [31:0] mbox [MAILBOX_WORDS];

  iobad_pkg::out_beat_t decoded_q [$];
  iobad_pkg::out_beat_t want;

  function automatic logic [31:0] mbox_rd(logic [3:0] i);
    if (int'(i) < MAILBOX_WORDS) return mbox[i];
    return '0;
  endfunction

  function automatic void mbox_wr(logic [3:0] i, logic [31:0] v);
    if (int'(i) < MAILBOX_WORDS) mbox[i] = v;
  endfunction

  function automatic bit is_ram_page(logic [15:0] page);
    return page < 16'h0080 || page[15:7] == 9'h100 || page[15:7] == 9'h140;
  endfunction

  function automatic logic [28:0] ram_off(logic [15:0] page, logic [15:0] lo);
    int pg;
    pg = int'(page[6:0]) % RAM_PAGES;
    return (29'(pg) << 16) | 29'(lo);
  endfunction

  // Pages that have a direct store for reads
  function automatic bit read_map(logic [15:0] page, logic [15:0] lo,
                                  output logic [3:0] rt, output logic [28:0] off);
    bit hit;
    hit = 1'b1;
    rt  = iobad_pkg::RT_UNMAPPED;
    off = '0;
    if (is_ram_page(page)) begin
      rt  = iobad_pkg::RT_RAM;
      off = ram_off(page, lo);
    end else if (page == iobad_pkg::P_EXP) begin
      rt  = iobad_pkg::RT_EXP;
      off = {13'h0, lo};
    end else if (page == {3'b000, iobad_pkg::T_SCRATCH} ||
                 page == {3'b101, iobad_pkg::T_SCRATCH}) begin
      rt  = iobad_pkg::RT_SCRATCH;
      off = {13'h0, lo};
    end else if ((page & iobad_pkg::ROM_MASK) == iobad_pkg::P_ROM_A ||
                 (page & iobad_pkg::ROM_MASK) == iobad_pkg::P_ROM_B ||
                 (page & iobad_pkg::ROM_MASK) == iobad_pkg::P_ROM_C) begin
      rt  = iobad_pkg::RT_ROM;
      off = {7'h0, page[5:0], lo};
    end else if ((page & iobad_pkg::ROM1_MASK) == iobad_pkg::P_ROM1_A ||
                 (page & iobad_pkg::ROM1_MASK) == iobad_pkg::P_ROM1_B ||
                 (page & iobad_pkg::ROM1_MASK) == iobad_pkg::P_ROM1_C) begin
      rt  = iobad_pkg::RT_ROM1;
      off = {11'h0, page[1:0], lo};
    end else if (page == iobad_pkg::P_MB_A || page == iobad_pkg::P_MB_B) begin
      rt  = iobad_pkg::RT_MBSTORE;
      off = {13'h0, lo};
    end else begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  // Pages that take writes directly: RAM while enabled, and expansion
  function automatic bit write_map(logic [15:0] page, logic [15:0] lo,
                                   output logic [3:0] rt, output logic [28:0] off);
    bit hit;
    hit = 1'b1;
    rt  = iobad_pkg::RT_UNMAPPED;
    off = '0;
    if (ram_wr_en && is_ram_page(page)) begin
      rt  = iobad_pkg::RT_RAM;
      off = ram_off(page, lo);
    end else if (page == iobad_pkg::P_EXP) begin
      rt  = iobad_pkg::RT_EXP;
      off = {13'h0, lo};
    end else begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic [31:0] toggle_bits(logic [31:0] x, logic [31:0] v);
    logic [31:0] sel;
    sel = v & iobad_pkg::TGL_BITS;
    if ((v & iobad_pkg::TGL_HI_SEL) != 0) x = {x[31:16], iobad_pkg::TGL_NIBBLE, x[11:0]};
    if ((x & sel) != 0) x = x & ~sel;
    else x = x | sel;
    return x;
  endfunction

  function automatic void load_ctrl(logic [31:0] v);
    wr_ctrl = v;
    case (v)
      iobad_pkg::CTL_OFF_A, iobad_pkg::CTL_OFF_B, iobad_pkg::CTL_OFF_C,
      iobad_pkg::CTL_OFF_D, iobad_pkg::CTL_OFF_E, iobad_pkg::CTL_OFF_F,
      iobad_pkg::CTL_OFF_G: ram_wr_en = 1'b0;
      iobad_pkg::CTL_ON_A, iobad_pkg::CTL_ON_B: ram_wr_en = 1'b1;
      default: ;
    endcase
  endfunction

  // Decode one access, updating the shadow state as the block would
  function automatic iobad_pkg::out_beat_t decode_access(iobad_pkg::in_beat_t b);
    logic [15:0] page;
    logic [12:0] t;
    logic [28:0] phys;
    logic [15:0] lo;
    logic [3:0]  idx;
    logic [1:0]  sz;
    logic [31:0] v;
    logic [31:0] cur;
    logic [3:0]  m_rt;
    logic [28:0] m_off;
    iobad_pkg::out_beat_t r;
    page = b.address[31:16];
    t    = page[12:0];
    phys = b.address[28:0];
    lo   = b.address[15:0];
    idx  = b.address[7:4];
    sz   = (b.access_size == iobad_pkg::SZ_RSVD) ? iobad_pkg::SZ_WORD : b.access_size;
    v    = b.write_data;
    if (sz == iobad_pkg::SZ_BYTE) v = {24'h0, v[7:0]};
    else if (sz == iobad_pkg::SZ_HALF) v = {16'h0, v[15:0]};
    r.route              = iobad_pkg::RT_UNMAPPED;
    r.target_offset      = phys;
    r.read_data          = '0;
    r.invalidate         = 1'b0;
    r.invalidate_address = '0;
    cur = mbox_rd(idx);

    if (t == iobad_pkg::T_SCRATCH) begin
      if (phys < iobad_pkg::HWREGS_BASE) begin
        r.route         = iobad_pkg::RT_SCRATCH;
        r.target_offset = {13'h0, lo};
      end else begin
        r.route = iobad_pkg::RT_HWREGS;
      end
    end else if (sz == iobad_pkg::SZ_BYTE && t == iobad_pkg::T_HW4) begin
      r.route = iobad_pkg::RT_HW4;
    end else if (b.op == iobad_pkg::OP_READ) begin
      if (read_map(page, lo, m_rt, m_off)) begin
        if (sz != iobad_pkg::SZ_BYTE && t == iobad_pkg::T_MAILBOX) begin
          r.route = iobad_pkg::RT_INTERNAL;
          if (idx == iobad_pkg::MB_BASE_IDX || idx == iobad_pkg::MB_SET_IDX ||
              (sz == iobad_pkg::SZ_WORD &&
               (idx == iobad_pkg::MB_CLR_IDX || idx == iobad_pkg::MB_OR_IDX))) begin
            r.read_data = cur;
          end else if (idx == iobad_pkg::MB_TGL_IDX) begin
            r.read_data = cur | ((sz == iobad_pkg::SZ_HALF) ? iobad_pkg::MB_HALF_OR
                                                             : iobad_pkg::MB_WORD_OR);
          end else if (idx == iobad_pkg::MB_ZERO_IDX) begin
            r.read_data = '0;
          end else begin
            r.route         = iobad_pkg::RT_SCRATCH;
            r.target_offset = {13'h0, lo};
          end
          if (sz == iobad_pkg::SZ_HALF) r.read_data[31:16] = '0;
        end else begin
          r.route         = m_rt;
          r.target_offset = m_off;
        end
      end else if (t == iobad_pkg::T_BAY) begin
        r.route = iobad_pkg::RT_BAY;
      end else if (sz == iobad_pkg::SZ_HALF && t == iobad_pkg::T_SOUND) begin
        r.route = iobad_pkg::RT_SOUND;
      end else if (sz == iobad_pkg::SZ_WORD && b.address == iobad_pkg::CTRL_ADDR) begin
        r.route     = iobad_pkg::RT_INTERNAL;
        r.read_data = wr_ctrl;
      end
    end else begin
      if (write_map(page, lo, m_rt, m_off)) begin
        r.route              = m_rt;
        r.target_offset      = m_off;
        r.invalidate         = 1'b1;
        r.invalidate_address = {b.address[31:2], 2'b00};
      end else if (sz == iobad_pkg::SZ_WORD && b.address == iobad_pkg::CTRL_ADDR) begin
        r.route = iobad_pkg::RT_INTERNAL;
        load_ctrl(v);
      end else if (t == iobad_pkg::T_MAILBOX) begin
        r.route = iobad_pkg::RT_INTERNAL;
        if (sz == iobad_pkg::SZ_HALF && idx == iobad_pkg::MB_SET_IDX)
          mbox_wr(idx, {cur[31:16], v[15:0]});
        else if (sz == iobad_pkg::SZ_WORD && idx == iobad_pkg::MB_SET_IDX)
          mbox_wr(idx, v);
        else if (sz == iobad_pkg::SZ_WORD && idx == iobad_pkg::MB_CLR_IDX)
          mbox_wr(idx, cur & ~v);
        else if (sz == iobad_pkg::SZ_WORD && idx == iobad_pkg::MB_OR_IDX)
          mbox_wr(idx, cur | v);
        else if (sz != iobad_pkg::SZ_BYTE && idx == iobad_pkg::MB_TGL_IDX)
          mbox_wr(idx, toggle_bits(cur, v));
        else if (sz != iobad_pkg::SZ_BYTE && idx == iobad_pkg::MB_ZERO_IDX)
          mbox_wr(idx, '0);
        else begin
          r.route         = iobad_pkg::RT_MBSTORE;
          r.target_offset = {13'h0, lo};
          if (sz == iobad_pkg::SZ_WORD) mbox_wr(idx, v);
        end
      end else if (t == iobad_pkg::T_BAY) begin
        r.route = iobad_pkg::RT_BAY;
      end else if (sz == iobad_pkg::SZ_HALF && t == iobad_pkg::T_SOUND) begin
        r.route = iobad_pkg::RT_SOUND;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ram_wr_en = 1'b1;
      wr_ctrl   = '0;
      for (int k = 0; k < MAILBOX_WORDS; k++) mbox[k] = '0;
      decoded_q.delete();
    end else begin
      // result side first: a beat leaving now belongs to an older access
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: route=%0d off=%h rd=%h inv=%b inva=%h",
                     out_data.route, out_data.target_offset, out_data.read_data,
                     out_data.invalidate, out_data.invalidate_address);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.route !== want.route ||
              out_data.target_offset !== want.target_offset ||
              out_data.read_data !== want.read_data ||
              out_data.invalidate !== want.invalidate ||
              out_data.invalidate_address !== want.invalidate_address) begin
            if (fail_count < 10)
              $display("mismatch: exp route=%0d off=%h rd=%h inv=%b inva=%h",
                       want.route, want.target_offset, want.read_data,
                       want.invalidate, want.invalidate_address,
                       " | got route=%0d off=%h rd=%h inv=%b inva=%h",
                       out_data.route, out_data.target_offset, out_data.read_data,
                       out_data.invalidate, out_data.invalidate_address);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) decoded_q.push_back(decode_access(in_data));
    end
    pending = decoded_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top-level bench for the I/O bus address decoder: clock, reset, access stimulus and verdict.
module testbench;

  // A typical run is far shorter than this limit.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 250;  // per random phase

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  iobad_pkg::in_beat_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  iobad_pkg::out_beat_t out_data;

  int send_idle_pct = 8;
  int recv_idle_pct = 86;
  int fail_count;
  int pending;
  int cycle_count   = 0;

  always #4 clk = ~clk;

  io_bus_address_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  iobad_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one access beat and hold it until taken. Called and returns at a
  // rising edge; ready is looked at on the falling edge, where it is settled.
  task automatic issue(logic op, logic [1:0] sz, logic [31:0] addr, logic [31:0] data);
    iobad_pkg::in_beat_t b;
    b.op          = op;
    b.access_size = sz;
    b.address     = addr;
    b.write_data  = data;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // One random access, biased towards the decoded regions.
  task automatic random_access();
    logic        op;
    logic [1:0]  sz;
    logic [2:0]  hi;
    logic [15:0] page;
    logic [15:0] lo;
    logic [31:0] data;
    logic [31:0] addr;
    logic [3:0]  idx;
    bit          to_ctrl;
    op      = 1'($urandom_range(1));
    sz      = ($urandom_range(15) == 0) ? iobad_pkg::SZ_RSVD : 2'($urandom_range(2));
    hi      = 3'($urandom);
    page    = 16'($urandom);
    lo      = 16'($urandom);
    data    = $urandom;
    to_ctrl = 1'b0;
    case ($urandom_range(19))
      0, 1: ;  // anywhere at all
      2, 3, 4: begin
        case ($urandom_range(2))
          0: page = 16'h0000;
          1: page = 16'h8000;
          default: page = 16'ha000;
        endcase
        page = page + 16'($urandom_range(16'h0080));  // includes the first page past RAM
      end
      5: page = ($urandom_range(3) == 0) ? {hi, iobad_pkg::P_EXP[12:0]} : iobad_pkg::P_EXP;
      6: begin
        page = {hi, iobad_pkg::T_SCRATCH};
        if ($urandom_range(1) == 1) lo = 16'h0ff8 + 16'($urandom_range(16));
      end
      7: page = {hi, iobad_pkg::T_HW4};
      8: begin
        case ($urandom_range(2))
          0: page = iobad_pkg::P_ROM_A;
          1: page = iobad_pkg::P_ROM_B;
          default: page = iobad_pkg::P_ROM_C;
        endcase
        page = page | 16'($urandom_range(63));
      end
      9: begin
        case ($urandom_range(2))
          0: page = iobad_pkg::P_ROM1_A;
          1: page = iobad_pkg::P_ROM1_B;
          default: page = iobad_pkg::P_ROM1_C;
        endcase
        page = page | 16'($urandom_range(3));
      end
      10, 11, 12, 13, 14: begin
        // mailbox: mostly the special word indexes, both store pages
        case ($urandom_range(5))
          0, 1, 2: page = iobad_pkg::P_MB_A;
          3, 4: page = iobad_pkg::P_MB_B;
          default: page = {hi, iobad_pkg::T_MAILBOX};
        endcase
        if ($urandom_range(2) != 0) begin
          case ($urandom_range(5))
            0: idx = iobad_pkg::MB_BASE_IDX;
            1: idx = iobad_pkg::MB_SET_IDX;
            2: idx = iobad_pkg::MB_CLR_IDX;
            3: idx = iobad_pkg::MB_OR_IDX;
            4: idx = iobad_pkg::MB_TGL_IDX;
            default: idx = iobad_pkg::MB_ZERO_IDX;
          endcase
        end else begin
          idx = 4'($urandom);
        end
        lo = {lo[15:8], idx, lo[3:0]};
        if (sz == iobad_pkg::SZ_BYTE && $urandom_range(1) == 1) sz = iobad_pkg::SZ_WORD;
      end
      15, 16: begin
        // write-control: magic values flip the RAM write enable both ways
        to_ctrl = 1'b1;
        if ($urandom_range(3) != 0) sz = iobad_pkg::SZ_WORD;
        if ($urandom_range(3) != 0) begin
          if ($urandom_range(1) == 1) begin
            data = ($urandom_range(1) == 1) ? iobad_pkg::CTL_ON_A : iobad_pkg::CTL_ON_B;
          end else begin
            case ($urandom_range(6))
              0: data = iobad_pkg::CTL_OFF_A;
              1: data = iobad_pkg::CTL_OFF_B;
              2: data = iobad_pkg::CTL_OFF_C;
              3: data = iobad_pkg::CTL_OFF_D;
              4: data = iobad_pkg::CTL_OFF_E;
              5: data = iobad_pkg::CTL_OFF_F;
              default: data = iobad_pkg::CTL_OFF_G;
            endcase
          end
        end
      end
      17: page = {hi, iobad_pkg::T_BAY};
      18: begin
        page = {hi, iobad_pkg::T_SOUND};
        if ($urandom_range(1) == 1) sz = iobad_pkg::SZ_HALF;
      end
      default: page = {hi, 13'($urandom)};
    endcase
    addr = to_ctrl ? iobad_pkg::CTRL_ADDR : {page, lo};
    issue(op, sz, addr, data);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: region edges, mailbox rules and write-control values.
    // RAM bottom
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_0000);
    // top RAM page folds
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_BYTE, 32'h007f_ffff, 32'hffff_ffff);
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'ha07f_fffe, 32'h1234_5678);
    // just past RAM
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_HALF, 32'h0080_0000, 32'h0000_0000);
    // expansion invalidates
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_HALF, 32'h1f00_1236, 32'h5555_aaaa);
    // last scratch word, then the first hw register
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'h1f80_0ffc, 32'h0000_0000);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'h1f80_1000, 32'h0000_0000);
    // hw4, bytes only
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_BYTE, 32'h1f40_0001, 32'h0000_0000);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'hbfc0_0100, 32'h0000_0000);
    // ROM is read-only
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'h1fff_0000, 32'hffff_ffff);
    // ROM1
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_HALF, 32'h9e03_fff0, 32'h0000_0000);
    // mailbox set, then the low half only
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'h1d00_0010, 32'hffff_ffff);
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_HALF, 32'h1d00_0010, 32'hcafe_1234);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'hbd00_0010, 32'h0000_0000);
    // clear mask, then OR
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'h1d00_0020, 32'h0f0f_0f0f);
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'h1d00_0030, 32'h8000_0001);
    // toggle, high-nibble load
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_HALF, 32'h1d00_0040, 32'h0000_00a0);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_HALF, 32'h1d00_0040, 32'h0000_0000);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'h1d00_0040, 32'h0000_0000);
    // plain store word; reading it back falls back to scratch
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'h1d00_0050, 32'hdead_beef);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'h1d00_0050, 32'h0000_0000);
    // RAM writes off, so this store is unmapped
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, iobad_pkg::CTRL_ADDR, iobad_pkg::CTL_OFF_F);
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, 32'h0000_1000, 32'h0000_0001);
    // size 3 acts as word
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_RSVD, iobad_pkg::CTRL_ADDR, 32'h0000_0000);
    // RAM writes back on
    issue(iobad_pkg::OP_WRITE, iobad_pkg::SZ_WORD, iobad_pkg::CTRL_ADDR, iobad_pkg::CTL_ON_B);
    // sound
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_HALF, 32'h1f90_0002, 32'h0000_0000);
    issue(iobad_pkg::OP_READ,  iobad_pkg::SZ_WORD, 32'hffff_ffff, 32'h0000_0000);

    // Phase one: sender mostly busy, receiver mostly stalled.
    for (int n = 0; n < RANDOM_BEATS; n++) random_access();
    drain_results();

    // Phase two: the other way round.
    send_idle_pct = 86;
    recv_idle_pct = 8;
    for (int n = 0; n < RANDOM_BEATS; n++) random_access();
    drain_results();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) random_access();
    drain_results();

    // idle on past the two-stage pipeline to catch stray beats
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/iobad_pkg.sv
design/io_bus_address_decoder.sv
sim/iobad_checker.sv
sim/testbench.sv
